>>> src/abp_pkg.sv
package abp_pkg;

	localparam int MAX_BODIES  = 64;
	localparam int COORD_BITS  = 32;
	localparam int HALF_BITS   = COORD_BITS - 1;
	localparam int MASK_BITS   = 16;
	localparam int ID_BITS     = 16;
	localparam int CNT_W       = $clog2(MAX_BODIES + 1);
	localparam int IDX_W       = $clog2(MAX_BODIES);
	localparam int QUEUE_DEPTH = 2;

	// input word as seen on the port
	typedef struct packed {
		logic                         frame_start;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic [HALF_BITS-1:0]         half_width;
		logic [HALF_BITS-1:0]         half_height;
		logic                         is_static;
		logic [MASK_BITS-1:0]         layer_mask;
		logic [ID_BITS-1:0]           body_id;
	} in_word_t;

	// output word, one per overlapping pair
	typedef struct packed {
		logic [ID_BITS-1:0] earlier_id;
		logic [ID_BITS-1:0] later_id;
		logic               last_of_run;
	} out_word_t;

	// body record as kept in the store; coordinates in offset binary
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [HALF_BITS-1:0]  hw;
		logic [HALF_BITS-1:0]  hh;
		logic                  stat;
		logic [MASK_BITS-1:0]  mask;
		logic [ID_BITS-1:0]    id;
	} body_t;

	// queued job between front and back
	typedef struct packed {
		logic  frame_start;
		body_t body;
	} job_t;

	typedef enum logic {
		B_IDLE,
		B_SCAN
	} back_state_t;

endpackage

>>> src/aabb_broadphase_pair_finder.sv
// Brute-force 2D AABB broadphase. Each input word is one body (centre,
// half extents, static flag, layer mask, id). A set frame_start empties the
// store before the body is handled. The body is tested against every body
// stored so far in the frame, and one output word leaves per overlapping pair
// (not both static, masks share a bit, boxes overlap or touch on both axes),
// in store order, with last_of_run set on the final pair of that body. The
// body is then stored; once MAX_BODIES bodies are held, further bodies of the
// frame are dropped without output. A body that meets a non-empty store
// occupies the scan engine until every stored body is compared and its last
// pair is handed to the output register; a body that meets an empty store, or
// is dropped, starts no scan. Output stalls hold the scan. The scan pace is set
// by the body store's single read port, which the engine walks one entry per
// cycle while no output stall holds it. A two-word queue in front keeps the
// input ready while a scan runs, and the output register lets the scan
// continue while a pair waits to be taken.
module aabb_broadphase_pair_finder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  abp_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output abp_pkg::out_word_t out_word
);
	import abp_pkg::*;

	job_t job;
	logic job_valid, job_ready;

	// front: converts coordinates to offset binary and queues bodies
	abp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job)
	);

	// back: stores the body and scans the store for overlapping pairs
	abp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

endmodule

>>> src/abp_ram.sv
module abp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/abp_front.sv
module abp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  abp_pkg::in_word_t in_word,
	output logic             job_valid,
	input  logic             job_ready,
	output abp_pkg::job_t    job
);
	import abp_pkg::*;

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	job_t              job_in;
	logic              push, pop;

	// sign bit flipped: offset binary keeps order and differences unsigned
	always_comb begin
		job_in.frame_start = in_word.frame_start;
		job_in.body.x      = {~in_word.center_x[COORD_BITS-1], in_word.center_x[COORD_BITS-2:0]};
		job_in.body.y      = {~in_word.center_y[COORD_BITS-1], in_word.center_y[COORD_BITS-2:0]};
		job_in.body.hw     = in_word.half_width;
		job_in.body.hh     = in_word.half_height;
		job_in.body.stat   = in_word.is_static;
		job_in.body.mask   = in_word.layer_mask;
		job_in.body.id     = in_word.body_id;
	end

	assign in_ready  = (fill_q != QCNT_W'(QUEUE_DEPTH));
	assign job_valid = (fill_q != '0);
	assign job       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

>>> src/abp_back.sv
module abp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  abp_pkg::job_t     job,
	output logic              out_valid,
	input  logic              out_ready,
	output abp_pkg::out_word_t out_word
);
	import abp_pkg::*;

	typedef struct packed {
		logic [COORD_BITS:0]   dx_ab;
		logic [COORD_BITS:0]   dx_ba;
		logic [COORD_BITS-1:0] sum_x;
		logic [COORD_BITS:0]   dy_ab;
		logic [COORD_BITS:0]   dy_ba;
		logic [COORD_BITS-1:0] sum_y;
		logic                  pass;
		logic [ID_BITS-1:0]    id;
	} cmp_t;

	back_state_t          state_q, state_d;
	logic [CNT_W-1:0]     count_q, cnt_eff, scan_len_q, idx_q;
	body_t                cur_q, rd_body;
	logic [$bits(body_t)-1:0] ram_rdata;
	logic                 v_s1, v_s2;
	cmp_t                 cmp_d, cmp_s2;
	logic [ID_BITS-1:0]   pend_id_q;
	logic                 pend_v_q;
	out_word_t            out_word_q;
	logic                 out_v_q;

	logic                 full, start, issue, finished, flush;
	logic                 out_free, adv, hit, take_hit, push_out;
	logic [COORD_BITS-1:0] dist_x, dist_y;

	assign cnt_eff  = job.frame_start ? '0 : count_q;
	assign full     = (cnt_eff == CNT_W'(MAX_BODIES));
	assign finished = (idx_q == scan_len_q) && !v_s1 && !v_s2;
	assign out_free = !out_v_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_valid && !full && (cnt_eff != '0)) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (finished && (!pend_v_q || out_free)) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		job_ready = 1'b0;
		issue     = 1'b0;
		flush     = 1'b0;
		case (state_q)
			B_IDLE: begin
				job_ready = 1'b1;
			end
			B_SCAN: begin
				issue = (idx_q != scan_len_q);
				flush = finished && pend_v_q && out_free;
			end
			default: begin
				job_ready = 1'b0;
			end
		endcase
	end

	assign start = job_valid && job_ready && !full;

	// s2 decision: pick the non-negative difference, compare with the extent sum
	assign dist_x = cmp_s2.dx_ab[COORD_BITS] ? cmp_s2.dx_ba[COORD_BITS-1:0]
	                                         : cmp_s2.dx_ab[COORD_BITS-1:0];
	assign dist_y = cmp_s2.dy_ab[COORD_BITS] ? cmp_s2.dy_ba[COORD_BITS-1:0]
	                                         : cmp_s2.dy_ab[COORD_BITS-1:0];
	assign hit      = v_s2 && cmp_s2.pass && (dist_x <= cmp_s2.sum_x) && (dist_y <= cmp_s2.sum_y);
	assign adv      = !hit || !pend_v_q || out_free;
	assign take_hit = hit && adv;
	assign push_out = (take_hit && pend_v_q) || flush;

	abp_ram #(
		.WIDTH($bits(body_t)),
		.DEPTH(MAX_BODIES)
	) u_store (
		.clk  (clk),
		.we   (start),
		.waddr(cnt_eff[IDX_W-1:0]),
		.wdata(job.body),
		.re   (issue && adv),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_body = body_t'(ram_rdata);

	// s1 -> s2: differences both ways and extent sums, in parallel
	always_comb begin
		cmp_d.dx_ab = {1'b0, rd_body.x} - {1'b0, cur_q.x};
		cmp_d.dx_ba = {1'b0, cur_q.x} - {1'b0, rd_body.x};
		cmp_d.sum_x = {1'b0, rd_body.hw} + {1'b0, cur_q.hw};
		cmp_d.dy_ab = {1'b0, rd_body.y} - {1'b0, cur_q.y};
		cmp_d.dy_ba = {1'b0, cur_q.y} - {1'b0, rd_body.y};
		cmp_d.sum_y = {1'b0, rd_body.hh} + {1'b0, cur_q.hh};
		cmp_d.pass  = !(rd_body.stat && cur_q.stat) && ((rd_body.mask & cur_q.mask) != '0);
		cmp_d.id    = rd_body.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			count_q    <= '0;
			scan_len_q <= '0;
			idx_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				count_q    <= cnt_eff + 1'b1;
				scan_len_q <= cnt_eff;
				idx_q      <= '0;
			end else if (issue && adv) begin
				idx_q <= idx_q + 1'b1;
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end
			if (take_hit) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
			if (push_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= job.body;
		end
		if (adv) begin
			cmp_s2 <= cmp_d;
		end
		if (take_hit) begin
			pend_id_q <= cmp_s2.id;
		end
		if (push_out) begin
			out_word_q.earlier_id  <= pend_id_q;
			out_word_q.later_id    <= cur_q.id;
			out_word_q.last_of_run <= flush;
		end
	end

	assign out_valid = out_v_q;
	assign out_word  = out_word_q;

endmodule
